@@ hw/rtl/rpd_pkg.sv @@
// shared types and constants of the rc pwm pulse decoder
// configuration record, lane and result records, register indexes
// no dependencies
package rpd_pkg;

   localparam logic [2:0] REG_CONFIRM_COUNT    = 3'd0;
   localparam logic [2:0] REG_FILTER_SHIFT     = 3'd1;
   localparam logic [2:0] REG_WIDTH_MIN        = 3'd2;
   localparam logic [2:0] REG_WIDTH_MAX        = 3'd3;
   localparam logic [2:0] REG_WIDTH_CENTER     = 3'd4;
   localparam logic [2:0] REG_TIMEOUT_TICKS    = 3'd5;
   localparam logic [2:0] REG_SPEED_FULL_SCALE = 3'd6;
   localparam logic [2:0] REG_SPEED_DEADBAND   = 3'd7;

   localparam logic [3:0]  CONFIRM_COUNT_RST    = 4'd3;
   localparam logic [3:0]  FILTER_SHIFT_RST     = 4'd3;
   localparam logic [7:0]  WIDTH_MIN_RST        = 8'd32;
   localparam logic [7:0]  WIDTH_MAX_RST        = 8'd64;
   localparam logic [7:0]  WIDTH_CENTER_RST     = 8'd48;
   localparam logic [15:0] TIMEOUT_TICKS_RST    = 16'd16000;
   localparam logic [12:0] SPEED_FULL_SCALE_RST = 13'd250;
   localparam logic [12:0] SPEED_DEADBAND_RST   = 13'd40;

   localparam logic [3:0] SHIFT_MAX     = 4'd8;
   localparam logic [7:0] STEER_FULL    = 8'd180;
   localparam logic [7:0] STEER_NEUTRAL = 8'd90;
   localparam int         RQ_DEPTH      = 3;

   typedef struct packed {
      logic [3:0]  confirm_count;
      logic [3:0]  filter_shift;
      logic [7:0]  width_min;
      logic [7:0]  width_max;
      logic [7:0]  width_center;
      logic [15:0] timeout_ticks;
      logic [12:0] speed_full_scale;
      logic [12:0] speed_deadband;
   } cfg_type;

   typedef struct packed {
      logic       upd;
      logic [5:0] x;
      logic       tmo;
   } lane_res_type;

   typedef struct packed {
      lane_res_type spd;
      lane_res_type str;
      logic         lost;
   } mid_type;

   typedef struct packed {
      logic signed [13:0] speed_mm_s;
      logic [7:0]         steer_deg;
      logic               drive_led;
      logic               keepalive;
      logic               signal_lost;
      logic               speed_update;
      logic               steer_update;
   } rsp_item_type;

endpackage

@@ hw/rtl/rpd_lane.sv @@
// one pin lane: confirmation counter, held level, width counter, leaky filter
// reports accepted falling edge, filtered position and timeout
// depends on rpd_pkg
module rpd_lane
   import rpd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic         pin,
   input  logic         lost,
   input  cfg_type      cfg,
   output lane_res_type res
);

   logic signed [4:0]  confirm_ff, confirm_in;
   logic               level_ff, level_in;
   logic [15:0]        width_ff, width_in;
   logic signed [13:0] filter_ff, filter_in;

   logic signed [4:0]  lim;
   logic signed [5:0]  sum;
   logic signed [5:0]  lim6;
   logic               win, fall, rise, level_mid;
   logic [15:0]        width_mid;
   logic [16:0]        width_inc;
   logic signed [17:0] diff;
   logic signed [5:0]  d;
   logic [3:0]         sh;
   logic signed [13:0] fsh, fnew, fout;
   logic signed [14:0] n;

   always_comb begin
      lim  = $signed({1'b0, cfg.confirm_count});
      lim6 = $signed({2'b00, cfg.confirm_count});
      sum  = $signed({confirm_ff[4], confirm_ff}) + (pin ? 6'sd1 : -6'sd1);
      if (sum > lim6) begin
         confirm_in = lim;
      end else if (sum < -lim6) begin
         confirm_in = -lim;
      end else begin
         confirm_in = sum[4:0];
      end

      win  = (width_ff <= {8'd0, cfg.width_max}) && (width_ff >= {8'd0, cfg.width_min});
      fall = (confirm_in == -lim) && level_ff && win;

      diff = $signed({2'b00, width_ff}) - $signed({10'd0, cfg.width_center});
      if (diff > 18'sd16) begin
         d = 6'sd16;
      end else if (diff < -18'sd16) begin
         d = -6'sd16;
      end else begin
         d = diff[5:0];
      end

      sh  = (cfg.filter_shift > SHIFT_MAX) ? SHIFT_MAX : cfg.filter_shift;
      fsh = filter_ff >>> sh;
      n   = $signed({filter_ff[13], filter_ff}) - $signed({fsh[13], fsh})
            + $signed({{9{d[5]}}, d});
      if (n > 15'sd8191) begin
         fnew = 14'sd8191;
      end else if (n < -15'sd8192) begin
         fnew = -14'sd8192;
      end else begin
         fnew = n[13:0];
      end
      fout = fnew >>> sh;
      if (fout > 14'sd16) begin
         res.x = 6'd32;
      end else if (fout < -14'sd16) begin
         res.x = 6'd0;
      end else begin
         res.x = fout[5:0] + 6'd16;
      end

      level_mid = fall ? 1'b0 : level_ff;
      rise      = (confirm_in == lim) && !level_mid;
      level_in  = rise ? 1'b1 : level_mid;
      width_mid = (fall || rise) ? 16'd0 : width_ff;
      width_inc = {1'b0, width_mid} + 17'd1;
      res.tmo   = width_inc > {1'b0, cfg.timeout_ticks};
      res.upd   = fall;
      width_in  = lost ? 16'd0 : width_inc[15:0];
      filter_in = fall ? fnew : filter_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         confirm_ff <= -$signed({1'b0, CONFIRM_COUNT_RST});
         level_ff   <= 1'b0;
         width_ff   <= 16'd0;
         filter_ff  <= 14'sd0;
      end else if (accept) begin
         confirm_ff <= confirm_in;
         level_ff   <= level_in;
         width_ff   <= width_in;
         filter_ff  <= filter_in;
      end
   end

endmodule

@@ hw/rtl/rpd_merge.sv @@
// merge stage: maps lane positions to speed and steer, deadband, timeout
// holds the commanded outputs and the led level
// depends on rpd_pkg
module rpd_merge
   import rpd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         mid_valid,
   input  mid_type      mid,
   input  cfg_type      cfg,
   output rsp_item_type item
);

   logic signed [13:0] speed_ff, speed_in;
   logic [7:0]         steer_ff, steer_in;
   logic               led_ff, led_in;

   logic [19:0]        prod;
   logic signed [14:0] v, db;
   logic [13:0]        sprod;
   logic               inband, keep;

   always_comb begin
      prod   = {14'd0, mid.spd.x} * {6'd0, cfg.speed_full_scale, 1'b0};
      v      = $signed({1'b0, prod[18:5]}) - $signed({2'b00, cfg.speed_full_scale});
      db     = $signed({2'b00, cfg.speed_deadband});
      inband = (v > -db) && (v < db);
      sprod  = {8'd0, mid.str.x} * {6'd0, STEER_FULL};

      speed_in = speed_ff;
      led_in   = led_ff;
      keep     = 1'b0;
      steer_in = steer_ff;
      if (mid.spd.upd) begin
         if (inband) begin
            speed_in = 14'sd0;
            led_in   = 1'b0;
         end else begin
            speed_in = v[13:0];
            led_in   = 1'b1;
            keep     = 1'b1;
         end
      end
      if (mid.str.upd) begin
         steer_in = STEER_FULL - sprod[12:5];
      end
      if (mid.lost) begin
         speed_in = 14'sd0;
         steer_in = STEER_NEUTRAL;
         led_in   = 1'b0;
      end

      item.speed_mm_s   = speed_in;
      item.steer_deg    = steer_in;
      item.drive_led    = led_in;
      item.keepalive    = keep;
      item.signal_lost  = mid.lost;
      item.speed_update = mid.spd.upd;
      item.steer_update = mid.str.upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= 14'sd0;
         steer_ff <= STEER_NEUTRAL;
         led_ff   <= 1'b0;
      end else if (mid_valid) begin
         speed_ff <= speed_in;
         steer_ff <= steer_in;
         led_ff   <= led_in;
      end
   end

endmodule

@@ hw/rtl/rpd_rsp_queue.sv @@
// small result queue between the merge stage and the result channel
// depth RQ_DEPTH, count drives the input credit check
// depends on rpd_pkg
module rpd_rsp_queue
   import rpd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_item_type push_item,
   input  logic         pop,
   output logic         not_empty,
   output rsp_item_type head,
   output logic [1:0]   count
);

   rsp_item_type entry_ff [RQ_DEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == 2'(RQ_DEPTH - 1)) ? 2'd0 : wr_ptr_ff + 2'd1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == 2'(RQ_DEPTH - 1)) ? 2'd0 : rd_ptr_ff + 2'd1;
      end
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign not_empty = (count_ff != 2'd0);
   assign head      = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

@@ hw/rtl/rc_pwm_pulse_decoder_unit.sv @@
// top level of the two-channel rc pwm pulse decoder
// instantiates two rpd_lane, rpd_merge and rpd_rsp_queue; depends on rpd_pkg
//
// Each transfer on req carries one sample tick of the speed and steer pins and
// yields exactly one transfer on rsp with the outputs as they stand after that
// tick. One sample is taken every cycle while req_stall is low; each result
// passes the mid stage register and then the result queue. The per-pin state
// (confirmation counter, level, width, filter) is updated in the lane stage in
// the accepting cycle; mapping and deadband follow in a second stage, and a
// three-entry result queue absorbs rsp stalls, with req_stall raised only when
// the queue and stage could not hold another result. Configuration registers
// are to be written by the user through the csr port while idle; the block does not enforce it.
module rc_pwm_pulse_decoder_unit
   import rpd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_speed_pin,
   input  logic               req_steer_pin,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [13:0] rsp_speed_mm_s,
   output logic [7:0]         rsp_steer_deg,
   output logic               rsp_drive_led,
   output logic               rsp_keepalive,
   output logic               rsp_signal_lost,
   output logic               rsp_speed_update,
   output logic               rsp_steer_update,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   cfg_type      cfg_ff;
   logic         accept;
   logic         lost;
   lane_res_type spd_res, str_res;
   logic         mid_valid_ff;
   mid_type      mid_ff;
   rsp_item_type merged, head;
   logic         pop;
   logic [1:0]   q_count;
   logic [2:0]   index;
   logic         cfg_write;

   assign csr_pready = 1'b1;
   assign index      = csr_paddr[4:2];
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.confirm_count    <= CONFIRM_COUNT_RST;
         cfg_ff.filter_shift     <= FILTER_SHIFT_RST;
         cfg_ff.width_min        <= WIDTH_MIN_RST;
         cfg_ff.width_max        <= WIDTH_MAX_RST;
         cfg_ff.width_center     <= WIDTH_CENTER_RST;
         cfg_ff.timeout_ticks    <= TIMEOUT_TICKS_RST;
         cfg_ff.speed_full_scale <= SPEED_FULL_SCALE_RST;
         cfg_ff.speed_deadband   <= SPEED_DEADBAND_RST;
      end else if (cfg_write) begin
         unique case (index)
            REG_CONFIRM_COUNT:    cfg_ff.confirm_count    <= csr_pwdata[3:0];
            REG_FILTER_SHIFT:     cfg_ff.filter_shift     <= csr_pwdata[3:0];
            REG_WIDTH_MIN:        cfg_ff.width_min        <= csr_pwdata[7:0];
            REG_WIDTH_MAX:        cfg_ff.width_max        <= csr_pwdata[7:0];
            REG_WIDTH_CENTER:     cfg_ff.width_center     <= csr_pwdata[7:0];
            REG_TIMEOUT_TICKS:    cfg_ff.timeout_ticks    <= csr_pwdata[15:0];
            REG_SPEED_FULL_SCALE: cfg_ff.speed_full_scale <= csr_pwdata[12:0];
            REG_SPEED_DEADBAND:   cfg_ff.speed_deadband   <= csr_pwdata[12:0];
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_CONFIRM_COUNT:    csr_prdata = {28'd0, cfg_ff.confirm_count};
         REG_FILTER_SHIFT:     csr_prdata = {28'd0, cfg_ff.filter_shift};
         REG_WIDTH_MIN:        csr_prdata = {24'd0, cfg_ff.width_min};
         REG_WIDTH_MAX:        csr_prdata = {24'd0, cfg_ff.width_max};
         REG_WIDTH_CENTER:     csr_prdata = {24'd0, cfg_ff.width_center};
         REG_TIMEOUT_TICKS:    csr_prdata = {16'd0, cfg_ff.timeout_ticks};
         REG_SPEED_FULL_SCALE: csr_prdata = {19'd0, cfg_ff.speed_full_scale};
         REG_SPEED_DEADBAND:   csr_prdata = {19'd0, cfg_ff.speed_deadband};
      endcase
   end

   // credit check: queued results plus the one in the merge stage
   assign req_stall = ({1'b0, q_count} + {2'd0, mid_valid_ff}) >= 3'(RQ_DEPTH);
   assign accept    = req_valid && !req_stall;
   assign lost      = spd_res.tmo || str_res.tmo;

   rpd_lane u_speed_lane (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .pin    (req_speed_pin),
      .lost   (lost),
      .cfg    (cfg_ff),
      .res    (spd_res)
   );

   rpd_lane u_steer_lane (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .pin    (req_steer_pin),
      .lost   (lost),
      .cfg    (cfg_ff),
      .res    (str_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else begin
         mid_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mid_ff.spd  <= spd_res;
         mid_ff.str  <= str_res;
         mid_ff.lost <= lost;
      end
   end

   rpd_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .mid_valid (mid_valid_ff),
      .mid       (mid_ff),
      .cfg       (cfg_ff),
      .item      (merged)
   );

   assign pop = rsp_valid && !rsp_stall;

   rpd_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_valid_ff),
      .push_item (merged),
      .pop       (pop),
      .not_empty (rsp_valid),
      .head      (head),
      .count     (q_count)
   );

   assign rsp_speed_mm_s   = head.speed_mm_s;
   assign rsp_steer_deg    = head.steer_deg;
   assign rsp_drive_led    = head.drive_led;
   assign rsp_keepalive    = head.keepalive;
   assign rsp_signal_lost  = head.signal_lost;
   assign rsp_speed_update = head.speed_update;
   assign rsp_steer_update = head.steer_update;

endmodule

@@ hw/rtl/rpd_checker.sv @@
// port-level checker for rc_pwm_pulse_decoder_unit, bound to the top level
// checks result channel hold and relations between result fields
// no dependencies
module rpd_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [13:0] rsp_speed_mm_s,
   input logic [7:0]         rsp_steer_deg,
   input logic               rsp_drive_led,
   input logic               rsp_keepalive,
   input logic               rsp_signal_lost,
   input logic               rsp_speed_update
);

   // stalled transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_speed_mm_s)
         && $stable(rsp_steer_deg))
      else $error("stalled result changed");

   // timeout forces neutral outputs
   a_lost_neutral: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_signal_lost |-> rsp_speed_mm_s == 14'sd0
         && rsp_steer_deg == 8'd90 && !rsp_drive_led)
      else $error("signal lost without neutral outputs");

   // keepalive only with an accepted speed pulse outside the deadband
   a_keep_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_keepalive |-> rsp_speed_update
         && (rsp_drive_led || rsp_signal_lost))
      else $error("keepalive without speed update");

   // speed pulse inside the deadband reads as zero speed
   a_deadband_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_speed_update && !rsp_keepalive |->
         rsp_speed_mm_s == 14'sd0 && !rsp_drive_led)
      else $error("deadband speed not zero");

endmodule

bind rc_pwm_pulse_decoder_unit rpd_checker u_rpd_checker (.*);
